/* sv/mpd_pkg.sv */
// Shared codes, field widths and controller/datapath interface structs.
package mpd_pkg;

  localparam int OP_W    = 2;
  localparam int NODE_W  = 5;
  localparam int CNT_W   = 6;
  localparam int OUT_LIMIT = 32;

  localparam logic [OP_W-1:0]  OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0]  OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0]  OP_FIND  = 2'd2;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

  typedef struct packed {
    logic capture;
    logic clr_graph;
    logic rd_a;
    logic wr_a;
    logic rd_b;
    logic wr_b;
    logic q_init;
    logic push;
    logic pop;
    logic pop_ld;
    logic em_rd;
    logic em_load;
    logic out_single;
    logic out_nopath;
  } mpd_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            edge_ok;
    logic            start_ok;
    logic            start_eq;
    logic            cand_any;
    logic            hit_finish;
    logic            depth_one;
    logic            out_free;
    logic            em_last;
  } mpd_sts_t;

endpackage

/* sv/mpd_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module mpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/mpd_datapath.sv */
// Datapath: adjacency and stack memories, visited marks, search registers, output word.
module mpd_datapath #(
  parameter int MAX_NODES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mpd_pkg::mpd_cmd_t   cmd,
  output mpd_pkg::mpd_sts_t   sts,
  input  logic [15:0]         in_tdata,
  input  logic                cfg_tvalid,
  input  logic [7:0]          cfg_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  localparam int IW   = $clog2(MAX_NODES);
  localparam int DW   = $clog2(MAX_NODES + 1);
  localparam int CMPW = (IW > mpd_pkg::NODE_W) ? IW : mpd_pkg::NODE_W;
  localparam logic [MAX_NODES-1:0] ONE = MAX_NODES'(1);

  logic [mpd_pkg::OP_W-1:0]   op_r;
  logic [mpd_pkg::NODE_W-1:0] a_r, b_r;
  logic [mpd_pkg::CNT_W-1:0]  node_count_r;
  logic [MAX_NODES-1:0]       row_vld_r, visited_r, nmask_r;
  logic                       rvld_r;
  logic [IW-1:0]              cur_r;
  logic [DW-1:0]              curj_r, depth_r, k_r;
  logic                       out_valid_r, out_found_r, out_last_r;
  logic [mpd_pkg::NODE_W-1:0] out_node_r;

  logic [IW-1:0]        a_idx, b_idx, j_idx;
  logic [MAX_NODES-1:0] adj_q, row, cand, lowest, nmask_nxt;
  logic [IW-1:0]        path_q;
  logic [DW-1:0]        res_q;
  logic                 adj_wr, adj_rd, path_wr, path_rd;
  logic [IW-1:0]        adj_waddr, adj_raddr, path_waddr, stk_raddr;
  logic [MAX_NODES-1:0] adj_wdata;
  logic [IW-1:0]        path_wdata;
  logic                 ld_any;

  assign a_idx = IW'(a_r);
  assign b_idx = IW'(b_r);

  assign row    = adj_q & {MAX_NODES{rvld_r}};
  assign cand   = row & ~visited_r & ({MAX_NODES{1'b1}} << curj_r) & nmask_r;
  assign lowest = cand & (~cand + ONE);

  always_comb begin
    j_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (lowest[i]) begin
        j_idx = j_idx | IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      nmask_nxt[i] = (i < 32'(node_count_r));
    end
  end

  // status back to the controller
  assign sts.op         = op_r;
  assign sts.edge_ok    = (32'(a_r) < MAX_NODES) && (32'(b_r) < MAX_NODES);
  assign sts.start_ok   = (32'(a_r) < MAX_NODES);
  assign sts.start_eq   = (a_r == b_r);
  assign sts.cand_any   = |cand;
  assign sts.hit_finish = (CMPW'(j_idx) == CMPW'(b_r));
  assign sts.depth_one  = (depth_r == DW'(1));
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.em_last    = ((32'(k_r) + 32'd1) ==
                           ((32'(depth_r) > mpd_pkg::OUT_LIMIT) ?
                            mpd_pkg::OUT_LIMIT : 32'(depth_r)));

  // adjacency rows
  assign adj_wr    = cmd.wr_a || cmd.wr_b;
  assign adj_waddr = cmd.wr_a ? a_idx : b_idx;
  assign adj_wdata = row | (cmd.wr_a ? (ONE << b_idx) : (ONE << a_idx));
  assign adj_rd    = cmd.rd_a || cmd.rd_b || cmd.q_init || cmd.push || cmd.pop_ld;

  always_comb begin
    adj_raddr = a_idx;
    if (cmd.rd_b) begin
      adj_raddr = b_idx;
    end else if (cmd.push) begin
      adj_raddr = j_idx;
    end else if (cmd.pop_ld) begin
      adj_raddr = path_q;
    end
  end

  mpd_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj (
    .clk     (clk),
    .wr_en   (adj_wr),
    .wr_addr (adj_waddr),
    .wr_data (adj_wdata),
    .rd_en   (adj_rd),
    .rd_addr (adj_raddr),
    .rd_data (adj_q)
  );

  // path and resume stacks
  assign path_wr    = cmd.q_init || cmd.push;
  assign path_waddr = cmd.push ? IW'(depth_r) : '0;
  assign path_wdata = cmd.push ? j_idx : a_idx;
  assign path_rd    = cmd.pop || cmd.em_rd;
  assign stk_raddr  = cmd.em_rd ? IW'(k_r) : IW'(depth_r - DW'(2));

  mpd_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_path (
    .clk     (clk),
    .wr_en   (path_wr),
    .wr_addr (path_waddr),
    .wr_data (path_wdata),
    .rd_en   (path_rd),
    .rd_addr (stk_raddr),
    .rd_data (path_q)
  );

  mpd_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_resume (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (IW'(depth_r - DW'(1))),
    .wr_data (DW'(j_idx) + DW'(1)),
    .rd_en   (cmd.pop),
    .rd_addr (IW'(depth_r - DW'(2))),
    .rd_data (res_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= mpd_pkg::NODE_COUNT_RST;
      row_vld_r    <= '0;
      visited_r    <= '0;
      depth_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_tvalid) begin
        node_count_r <= cfg_tdata[mpd_pkg::CNT_W-1:0];
      end
      if (cmd.clr_graph) begin
        row_vld_r <= '0;
      end else if (adj_wr) begin
        row_vld_r <= row_vld_r | (ONE << adj_waddr);
      end
      if (cmd.q_init) begin
        visited_r <= ONE << a_idx;
        depth_r   <= DW'(1);
      end else if (cmd.push) begin
        visited_r <= visited_r | (ONE << j_idx);
        depth_r   <= depth_r + DW'(1);
      end else if (cmd.pop) begin
        depth_r   <= depth_r - DW'(1);
      end else if (cmd.out_nopath) begin
        depth_r   <= '0;
      end
      if (ld_any) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign ld_any = cmd.em_load || cmd.out_single || cmd.out_nopath;

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_tdata[1:0];
      a_r  <= in_tdata[6:2];
      b_r  <= in_tdata[11:7];
    end
    if (adj_rd) begin
      rvld_r <= row_vld_r[adj_raddr];
    end
    if (cmd.q_init) begin
      cur_r   <= a_idx;
      curj_r  <= '0;
      k_r     <= '0;
      nmask_r <= nmask_nxt;
    end else if (cmd.push) begin
      cur_r  <= j_idx;
      curj_r <= '0;
    end else if (cmd.pop_ld) begin
      cur_r  <= path_q;
      curj_r <= res_q;
    end else if (cmd.em_load) begin
      k_r <= k_r + DW'(1);
    end
    if (cmd.em_load) begin
      out_node_r  <= mpd_pkg::NODE_W'(path_q);
      out_found_r <= 1'b1;
      out_last_r  <= sts.em_last;
    end else if (cmd.out_single) begin
      out_node_r  <= a_r;
      out_found_r <= 1'b1;
      out_last_r  <= 1'b1;
    end else if (cmd.out_nopath) begin
      out_node_r  <= '0;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 8'(out_node_r);
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= MAX_NODES)
    else $error("stack depth beyond node range");

  a_push_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> visited_r[cur_r])
    else $error("pushed node not marked visited");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld_any |-> (!out_valid_r || out_tready))
    else $error("output word overwritten");

endmodule

/* sv/mpd_ctrl.sv */
// Controller state machine: decodes items, steps edge updates, search and path readout.
module mpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mpd_pkg::mpd_sts_t sts,
  output mpd_pkg::mpd_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_WR   = 4'd3;
  localparam logic [3:0] S_B_RD   = 4'd4;
  localparam logic [3:0] S_B_WR   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_POP_LD = 4'd7;
  localparam logic [3:0] S_EM_RD  = 4'd8;
  localparam logic [3:0] S_EM_OUT = 4'd9;
  localparam logic [3:0] S_SINGLE = 4'd10;
  localparam logic [3:0] S_NOPATH = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          mpd_pkg::OP_ADD: begin
            state_nxt = sts.edge_ok ? S_A_RD : S_IDLE;
          end
          mpd_pkg::OP_CLEAR: begin
            cmd.clr_graph = 1'b1;
            state_nxt     = S_IDLE;
          end
          mpd_pkg::OP_FIND: begin
            if (!sts.start_ok) begin
              state_nxt = S_NOPATH;
            end else if (sts.start_eq) begin
              state_nxt = S_SINGLE;
            end else begin
              cmd.q_init = 1'b1;
              state_nxt  = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_A_RD: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        cmd.wr_a  = 1'b1;
        state_nxt = S_B_RD;
      end
      S_B_RD: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (sts.cand_any) begin
          cmd.push  = 1'b1;
          state_nxt = sts.hit_finish ? S_EM_RD : S_SCAN;
        end else if (sts.depth_one) begin
          state_nxt = S_NOPATH;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP_LD;
        end
      end
      S_POP_LD: begin
        cmd.pop_ld = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_EM_RD: begin
        cmd.em_rd = 1'b1;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts.out_free) begin
          cmd.em_load = 1'b1;
          state_nxt   = sts.em_last ? S_IDLE : S_EM_RD;
        end
      end
      S_SINGLE: begin
        if (sts.out_free) begin
          cmd.out_single = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_NOPATH: begin
        if (sts.out_free) begin
          cmd.out_nopath = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECODE))
    else $error("accepted word not decoded");

  a_scan_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.pop, cmd.pop_ld, cmd.q_init, cmd.em_rd}))
    else $error("conflicting stack commands");

  a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EM_RD) |-> ($past(cmd.push) || $past(cmd.em_load)))
    else $error("path readout entered without a hit");

endmodule

/* sv/maze_path_dfs.sv */
// Top level of the depth-first path finder over an adjacency bit matrix.
// Edge word: decode, rows a and b read/write; clear/unused op: decode. A word is
// accepted only when idle. Query: decode, scan per forward step, pop and reload per
// backtrack, registered stack read per path node; start equal to finish or no path:
// one output word. The output word register lets the next item enter while the last
// result waits. Reset (synchronous, rst_n low) empties the graph via row valid bits.
module maze_path_dfs #(
  parameter int MAX_NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], node_a[6:2], node_b[11:7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // node[4:0]
  output logic        out_tuser,  // found[0]
  output logic        out_tlast,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // node_count[5:0]
);

  mpd_pkg::mpd_cmd_t cmd;
  mpd_pkg::mpd_sts_t sts;

  assign cfg_tready = 1'b1;

  mpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpd_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tdata  (cfg_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
